/* rtl/mtsm_pkg.sv */
`timescale 1ns / 1ps

package mtsm_pkg;

    // Window and timeout, in sample ticks
    localparam logic [6:0]  WindowLen   = 7'd100;
    localparam logic [5:0]  IdleTimeout = 6'd50;

    // Counter value requested on reload
    localparam logic [15:0] Baseline    = 16'd32760;

    // 60 s/min * 1000 Hz/kHz
    localparam logic [15:0] RpmScale    = 16'd60000;

    // Register indexes of the configuration port
    localparam logic CfgLineCount = 1'b0;
    localparam logic CfgTickKhz   = 1'b1;

    localparam logic [15:0] LineCountRst = 16'd500;
    localparam logic [15:0] TickKhzRst   = 16'd1;

    // Quotient bits produced by the divider; anything at or above 2**QuoBits saturates
    localparam int unsigned QuoBits = 17;
    localparam int unsigned CntW    = $clog2(QuoBits);

    localparam int unsigned NumW = 48;
    localparam int unsigned DenW = 26;

    localparam logic [15:0] SpeedMax = 16'h7FFF;
    localparam logic [15:0] SpeedMin = 16'h8000;

    typedef struct packed {
        logic        reload;
        logic [15:0] pulses;
        logic [7:0]  period;
    } t_meas;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_MUL_A,
        SQ_MUL_B,
        SQ_MUL_C,
        SQ_CHECK,
        SQ_DIV,
        SQ_DONE
    } t_sq_state;

endpackage

/* rtl/mt_encoder_speed_measure_core.sv */
`timescale 1ns / 1ps

// M/T encoder speed measurement.
// Input channel: one beat per sample tick carries the quadrature counter value
// (i_encoder_count). Output channel: one beat per input beat with the signed
// speed in r/min, a request to reload the counter to its baseline, and a flag
// for a zero latched period.
// Configuration: i_cfg_we writes line count (index 0) or tick rate in kHz
// (index 1) at once; write only while no beat is in flight.
// Path: a normal tick takes three passes through the shared multiplier and
// seventeen restoring divide steps; a quotient too large for 17 bits skips the
// divide and saturates, and a zero period or a zero line count goes straight
// to the result. A new input beat is taken once the previous result has moved
// into the output register, so only one tick is in flight at a time.
// Stall: if the receiver holds i_out_ready low, the finished result waits in
// the divider and o_in_ready stays low until the output register frees up.
// Reset: registers return to 500 lines and 1 kHz, the window is marked
// complete, the latched period and pulse count are cleared, no beat is valid.

module mt_encoder_speed_measure_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_encoder_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_speed_rpm,
    output logic        o_reload_counter,
    output logic        o_no_period
);
    import mtsm_pkg::*;

    logic [15:0] r_line_count;
    logic [15:0] r_tick_khz;
    logic        r_busy;
    logic        r_start;
    logic        r_out_valid;
    logic [15:0] r_speed;
    logic        r_reload;
    logic        r_noper;

    logic        in_acc;
    logic        take;
    logic        done;
    logic [15:0] speed;
    logic        noper;
    t_meas       meas;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign take       = done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= LineCountRst;
            r_tick_khz   <= TickKhzRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgLineCount: r_line_count <= i_cfg_data;
                CfgTickKhz:   r_tick_khz   <= i_cfg_data;
                default:      r_line_count <= r_line_count;
            endcase
        end
    end

    mtsm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (in_acc),
        .i_count  (i_encoder_count),
        .o_meas   (meas)
    );

    mtsm_speed_unit u_speed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_meas       (meas),
        .i_line_count (r_line_count),
        .i_tick_khz   (r_tick_khz),
        .i_take       (take),
        .o_done       (done),
        .o_speed      (speed),
        .o_no_period  (noper)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_acc;
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the output beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_speed  <= speed;
            r_reload <= meas.reload;
            r_noper  <= noper;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_rpm      = r_speed;
    assign o_reload_counter = r_reload;
    assign o_no_period      = r_noper;

endmodule

/* rtl/mtsm_window.sv */
`timescale 1ns / 1ps

module mtsm_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  logic [15:0]         i_count,
    output mtsm_pkg::t_meas     o_meas
);
    import mtsm_pkg::*;

    logic [6:0]  r_wt,     n_wt;
    logic [6:0]  r_lead,   n_lead;
    logic [5:0]  r_trail,  n_trail;
    logic [7:0]  r_period, n_period;
    logic [15:0] r_ref,    n_ref;
    logic [15:0] r_pulses, n_pulses;
    logic        r_reload, n_reload;

    logic        cnt_eq;
    logic        win_done;
    logic [5:0]  trail_inc;
    logic        do_latch;
    logic [7:0]  latch_per;
    logic [6:0]  wt_mid;

    always_comb begin
        n_lead    = r_lead;
        n_trail   = r_trail;
        n_period  = r_period;
        n_ref     = r_ref;
        n_pulses  = r_pulses;
        n_reload  = 1'b0;
        do_latch  = 1'b0;
        latch_per = r_period;
        wt_mid    = r_wt;
        cnt_eq    = (i_count == r_ref);
        win_done  = (r_wt == WindowLen);
        trail_inc = r_trail + 6'd1;

        if (cnt_eq) begin
            if (win_done) begin
                n_trail = trail_inc;
                if (trail_inc > IdleTimeout) begin
                    do_latch  = 1'b1;
                    latch_per = {1'b0, WindowLen} - {1'b0, r_lead} + {2'b00, trail_inc} - 8'd1;
                end
            end else begin
                n_lead = r_lead + 7'd1;
            end
        end else if (win_done) begin
            do_latch  = 1'b1;
            latch_per = {1'b0, WindowLen} - {1'b0, r_lead} + {2'b00, r_trail};
        end

        // Latch the finished measurement and restart from the baseline
        if (do_latch) begin
            n_period = latch_per;
            n_pulses = r_ref - Baseline;
            wt_mid   = 7'd0;
            n_lead   = 7'd0;
            n_trail  = 6'd0;
            n_ref    = Baseline;
            n_reload = 1'b1;
        end

        n_wt = wt_mid;
        if (wt_mid < WindowLen) begin
            n_wt = wt_mid + 7'd1;
            if (n_wt == WindowLen) begin
                n_ref = i_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt     <= WindowLen;
            r_lead   <= '0;
            r_trail  <= '0;
            r_period <= '0;
            r_ref    <= '0;
            r_pulses <= '0;
            r_reload <= 1'b0;
        end else if (i_update) begin
            r_wt     <= n_wt;
            r_lead   <= n_lead;
            r_trail  <= n_trail;
            r_period <= n_period;
            r_ref    <= n_ref;
            r_pulses <= n_pulses;
            r_reload <= n_reload;
        end
    end

    assign o_meas.reload = r_reload;
    assign o_meas.pulses = r_pulses;
    assign o_meas.period = r_period;

endmodule

/* rtl/mtsm_speed_unit.sv */
`timescale 1ns / 1ps

module mtsm_speed_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mtsm_pkg::t_meas     i_meas,
    input  logic [15:0]         i_line_count,
    input  logic [15:0]         i_tick_khz,
    input  logic                i_take,
    output logic                o_done,
    output logic [15:0]         o_speed,
    output logic                o_no_period
);
    import mtsm_pkg::*;

    t_sq_state r_state, n_state;

    logic [NumW-1:0]   r_num;
    logic [DenW-1:0]   r_den;
    logic [NumW-1:0]   r_rem;
    logic [NumW-1:0]   r_dsr;
    logic [QuoBits-1:0] r_quo;
    logic [CntW-1:0]   r_cnt;
    logic              r_ovf;
    logic              r_noper;

    logic              neg;
    logic [15:0]       mag;
    logic              skip;
    logic [31:0]       mul_a;
    logic [15:0]       mul_b;
    logic [NumW-1:0]   product;
    logic              ovf_hit;
    logic [NumW:0]     trial;
    logic              fits;
    logic [15:0]       neg_q;

    assign neg  = i_meas.pulses[15];
    assign mag  = neg ? (16'd0 - i_meas.pulses) : i_meas.pulses;
    assign skip = (i_meas.period == 8'd0) || (i_line_count == 16'd0);

    // Shared multiplier, one product per cycle
    assign product = NumW'(mul_a) * NumW'(mul_b);

    assign ovf_hit = r_num >= {{(NumW-DenW-QuoBits){1'b0}}, r_den, {QuoBits{1'b0}}};
    assign trial   = {1'b0, r_rem} - {1'b0, r_dsr};
    assign fits    = !trial[NumW];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:  if (i_start) n_state = skip ? SQ_DONE : SQ_MUL_A;
            SQ_MUL_A: n_state = SQ_MUL_B;
            SQ_MUL_B: n_state = SQ_MUL_C;
            SQ_MUL_C: n_state = SQ_CHECK;
            SQ_CHECK: n_state = ovf_hit ? SQ_DONE : SQ_DIV;
            SQ_DIV:   if (r_cnt == '0) n_state = SQ_DONE;
            SQ_DONE:  if (i_take) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        o_done = 1'b0;
        unique case (r_state)
            SQ_MUL_A: begin
                mul_a = {16'd0, i_tick_khz};
                mul_b = mag;
            end
            SQ_MUL_B: begin
                mul_a = r_num[31:0];
                mul_b = RpmScale;
            end
            SQ_MUL_C: begin
                mul_a = {14'd0, i_line_count, 2'b00};
                mul_b = {8'd0, i_meas.period};
            end
            SQ_DONE:  o_done = 1'b1;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    r_noper <= (i_meas.period == 8'd0);
                    r_quo   <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            SQ_MUL_A, SQ_MUL_B: r_num <= product;
            SQ_MUL_C: r_den <= product[DenW-1:0];
            SQ_CHECK: begin
                r_ovf <= ovf_hit;
                r_rem <= r_num;
                r_dsr <= {{(NumW-DenW-QuoBits+1){1'b0}}, r_den, {(QuoBits-1){1'b0}}};
                r_cnt <= CntW'(QuoBits - 1);
            end
            SQ_DIV: begin
                if (fits) begin
                    r_rem <= trial[NumW-1:0];
                end
                r_quo <= {r_quo[QuoBits-2:0], fits};
                r_dsr <= r_dsr >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Truncated quotient, signed and clamped to 16 bits
    assign neg_q = 16'd0 - r_quo[15:0];

    always_comb begin
        if (neg) begin
            if (r_ovf || r_quo[16] || (r_quo[15] && (r_quo[14:0] != '0))) begin
                o_speed = SpeedMin;
            end else begin
                o_speed = neg_q;
            end
        end else begin
            if (r_ovf || r_quo[16] || r_quo[15]) begin
                o_speed = SpeedMax;
            end else begin
                o_speed = r_quo[15:0];
            end
        end
    end

    assign o_no_period = r_noper;

endmodule

/* rtl/mtsm_checker.sv */
`timescale 1ns / 1ps

module mtsm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] o_speed_rpm,
    input  logic        o_reload_counter,
    input  logic        o_no_period
);

    // A held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_speed_rpm) && $stable(o_reload_counter)
            && $stable(o_no_period))
        else $error("output beat changed while stalled");

    // One tick at a time: no second input beat right after one is taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while a tick is in flight");

    // Zero period forces zero speed
    a_noper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_period |-> o_speed_rpm == 16'd0)
        else $error("speed not zero with no period");

    // No result turns valid straight after an input beat is taken while none is valid
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind mt_encoder_speed_measure_core mtsm_checker u_mtsm_checker (.*);

/* bench/mtsm_speed_check.sv */
`timescale 1ns / 1ps

module mtsm_speed_check
    import mtsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_encoder_count,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_speed_rpm,
    input  logic        i_reload_counter,
    input  logic        i_no_period,
    output int          o_errors,
    output int          o_pending,
    output int          o_reloads,
    output int          o_clamped,
    output int          o_unperiod
);

    localparam int MaxReports = 10;

    typedef struct packed {
        logic [15:0] speed;
        logic        reload;
        logic        no_period;
    } t_speed_beat;

    // speed beats predicted but not yet seen on the output channel
    t_speed_beat speed_due[$];

    logic [15:0] line_count;
    logic [15:0] tick_khz;
    logic [6:0]  win_ticks;
    logic [6:0]  lead_idle;
    logic [5:0]  trail_idle;
    logic [7:0]  period;
    logic [15:0] ref_count;
    logic [15:0] pulses;

    int errors   = 0;
    int beats    = 0;
    int reloads  = 0;
    int clamped  = 0;
    int unperiod = 0;

    task automatic take_latch(input logic [7:0] new_period);
        period     = new_period;
        pulses     = ref_count - Baseline;
        win_ticks  = '0;
        lead_idle  = '0;
        trail_idle = '0;
        ref_count  = Baseline;
    endtask

    task automatic advance_speed_tick(input logic [15:0] cnt, output t_speed_beat res);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;

        res = '0;
        if (cnt == ref_count) begin
            if (win_ticks == WindowLen) begin
                trail_idle = trail_idle + 6'd1;
                if (trail_idle > IdleTimeout) begin
                    // timeout: the last idle tick is not part of the period
                    take_latch(8'(WindowLen) - 8'(lead_idle) + 8'(trail_idle) - 8'd1);
                    res.reload = 1'b1;
                end
            end else begin
                lead_idle = lead_idle + 7'd1;
            end
        end else if (win_ticks == WindowLen) begin
            take_latch(8'(WindowLen) - 8'(lead_idle) + 8'(trail_idle));
            res.reload = 1'b1;
        end

        if (win_ticks < WindowLen) begin
            win_ticks = win_ticks + 7'd1;
            if (win_ticks == WindowLen)
                ref_count = cnt;
        end

        if (period == 8'd0) begin
            res.no_period = 1'b1;
            unperiod++;
        end else if (line_count != 16'd0) begin
            neg = pulses[15];
            mag = neg ? 64'(17'h10000 - {1'b0, pulses}) : 64'(pulses);
            num = 64'(RpmScale) * 64'(tick_khz) * mag;
            den = 64'd4 * 64'(line_count) * 64'(period);
            quo = num / den;
            if (neg) begin
                if (quo > 64'd32768) begin
                    res.speed = SpeedMin;
                    clamped++;
                end else begin
                    res.speed = 16'(64'd0 - quo);
                end
            end else begin
                if (quo > 64'd32767) begin
                    res.speed = SpeedMax;
                    clamped++;
                end else begin
                    res.speed = quo[15:0];
                end
            end
        end
        if (res.reload)
            reloads++;
    endtask

    always @(posedge i_clk) begin
        t_speed_beat got;
        t_speed_beat want;

        if (!i_rst_n) begin
            line_count = LineCountRst;
            tick_khz   = TickKhzRst;
            win_ticks  = WindowLen;
            lead_idle  = '0;
            trail_idle = '0;
            period     = '0;
            ref_count  = '0;
            pulses     = '0;
            speed_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgLineCount: line_count = i_cfg_data;
                    CfgTickKhz:   tick_khz   = i_cfg_data;
                    default:      ;
                endcase
            end

            // drain before fill so a beat never matches one accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                got.speed     = i_speed_rpm;
                got.reload    = i_reload_counter;
                got.no_period = i_no_period;
                beats++;
                if (speed_due.size() == 0) begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("mtsm_speed_check: output beat %0d with nothing due: ",
                                 "speed %0d reload %0b no_period %0b",
                                 beats, $signed(got.speed), got.reload, got.no_period);
                end else begin
                    want = speed_due.pop_front();
                    if (got.speed !== want.speed || got.reload !== want.reload ||
                        got.no_period !== want.no_period) begin
                        errors++;
                        if (errors <= MaxReports)
                            $display("mtsm_speed_check: beat %0d expected speed %0d ",
                                     "reload %0b no_period %0b, got speed %0d ",
                                     "reload %0b no_period %0b",
                                     beats, $signed(want.speed), want.reload, want.no_period,
                                     $signed(got.speed), got.reload, got.no_period);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                advance_speed_tick(i_encoder_count, want);
                speed_due.push_back(want);
            end
        end

        o_errors   <= errors;
        o_pending  <= speed_due.size();
        o_reloads  <= reloads;
        o_clamped  <= clamped;
        o_unperiod <= unperiod;
    end

endmodule

/* bench/tb_mt_encoder_speed_measure_core.sv */
`timescale 1ns / 1ps

module tb_mt_encoder_speed_measure_core;
    import mtsm_pkg::*;

    localparam int QuietLimit  = 4000;
    localparam int DrainCycles = 60;
    localparam int PhaseCount  = 8;
    localparam int PhaseItems  = 154;

    typedef enum int {
        MOVE_NOISE,
        MOVE_HOLD,
        MOVE_SPIN,
        MOVE_CRAWL
    } t_move;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_idx       = 1'b0;
    logic [15:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic [15:0] i_encoder_count = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_speed_rpm;
    logic        o_reload_counter;
    logic        o_no_period;

    int errors;
    int pending;
    int reloads;
    int clamped;
    int unperiod;

    // opening ticks: zero period first, then extreme counts across a fresh window
    logic [15:0] opening_counts [16] = '{
        16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
        Baseline, Baseline, Baseline, Baseline + 16'd1,
        16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
        16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE
    };

    // encoder emulation
    logic [15:0] enc = Baseline;
    t_move       move = MOVE_SPIN;
    int          seg_left = 0;
    int          vel = 0;
    int          crawl_period = 1;
    int          crawl_phase = 0;
    bit          tx_calm = 1'b0;
    int          reloads_seen = 0;
    int          reloads_used = 0;

    int ticks_sent = 0;
    int settings   = 1;
    int quiet      = 0;
    int phase_idx;
    int beat_idx;

    always #10 i_clk = ~i_clk;

    mt_encoder_speed_measure_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_encoder_count  (i_encoder_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_rpm      (o_speed_rpm),
        .o_reload_counter (o_reload_counter),
        .o_no_period      (o_no_period)
    );

    mtsm_speed_check check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_encoder_count  (i_encoder_count),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_speed_rpm      (o_speed_rpm),
        .i_reload_counter (o_reload_counter),
        .i_no_period      (o_no_period),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_reloads        (reloads),
        .o_clamped        (clamped),
        .o_unperiod       (unperiod)
    );

    // the emulated counter follows reload requests as they leave the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready && o_reload_counter)
            reloads_seen <= reloads_seen + 1;
    end

    function automatic void start_segment();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 10)
            move = MOVE_NOISE;
        else if (pick < 25)
            move = MOVE_HOLD;
        else if (pick < 65)
            move = MOVE_SPIN;
        else
            move = MOVE_CRAWL;
        // hold for longer than the idle timeout so that it can fire
        seg_left = (move == MOVE_HOLD) ? $urandom_range(60, 220) : $urandom_range(20, 300);
        case ($urandom_range(0, 3))
            0:       vel = $urandom_range(1, 4);
            1:       vel = $urandom_range(5, 60);
            2:       vel = $urandom_range(61, 700);
            default: vel = $urandom_range(1, 65535);
        endcase
        if (move == MOVE_CRAWL)
            vel = 1;
        if ($urandom_range(0, 1))
            vel = -vel;
        crawl_period = $urandom_range(2, 70);
        crawl_phase  = 0;
        tx_calm      = ($urandom_range(0, 3) == 0);
    endfunction

    function automatic logic [15:0] next_count();
        if (seg_left == 0)
            start_segment();
        seg_left--;
        if (reloads_used != reloads_seen) begin
            reloads_used = reloads_seen;
            // now and then ignore the request to break the sequence
            if ($urandom_range(0, 9) != 0)
                enc = Baseline;
        end
        case (move)
            MOVE_NOISE: return 16'($urandom);
            MOVE_SPIN:  enc = enc + 16'(vel);
            MOVE_CRAWL: begin
                crawl_phase++;
                if (crawl_phase >= crawl_period) begin
                    crawl_phase = 0;
                    enc = enc + 16'(vel);
                end
            end
            default: ;
        endcase
        return enc;
    endfunction

    task automatic hold_gap();
        int gap;

        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_tick(input logic [15:0] value);
        i_in_valid      <= 1'b1;
        i_encoder_count <= value;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] lines, input logic [15:0] khz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CfgLineCount;
        i_cfg_data <= lines;
        @(posedge i_clk);
        i_cfg_idx  <= CfgTickKhz;
        i_cfg_data <= khz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings++;
    endtask

    initial begin : drain_side
        int stall;
        int calm_left;

        calm_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 12);
                if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(10, 60);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_mt_encoder_speed_measure_core: done, errors");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_counts[k]) begin
            hold_gap();
            push_tick(opening_counts[k]);
        end

        for (phase_idx = 0; phase_idx < PhaseCount; phase_idx++) begin
            // first phase runs on the reset settings
            if (phase_idx != 0) begin
                settle();
                case (phase_idx)
                    1:       configure(16'd1, 16'hFFFF);
                    2:       configure(16'hFFFF, 16'd1);
                    3:       configure(16'd0, 16'($urandom));
                    4:       configure(16'd1024, 16'($urandom_range(1, 64)));
                    7:       configure(16'hFFFF, 16'hFFFF);
                    default: configure(16'($urandom_range(1, 65535)),
                                       16'($urandom_range(1, 2000)));
                endcase
            end
            for (beat_idx = 0; beat_idx < PhaseItems; beat_idx++) begin
                hold_gap();
                push_tick(next_count());
            end
        end
        settle();

        $display("tb_mt_encoder_speed_measure_core: %0d ticks over %0d register settings",
                 ticks_sent, settings);
        $display("tb_mt_encoder_speed_measure_core: %0d reloads, %0d clamped speeds, ",
                 "%0d ticks with no period", reloads, clamped, unperiod);
        if (errors == 0 && pending == 0)
            $display("tb_mt_encoder_speed_measure_core: done, clean");
        else
            $display("tb_mt_encoder_speed_measure_core: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/mtsm_pkg.sv
rtl/mtsm_window.sv
rtl/mtsm_speed_unit.sv
rtl/mt_encoder_speed_measure_core.sv
rtl/mtsm_checker.sv
bench/mtsm_speed_check.sv
bench/tb_mt_encoder_speed_measure_core.sv
